[rtl/hcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared types and constants for the heat/cool selector with compressor guard.
// ----------------------------------------------------------------------------
package hcs_pkg;

	// operating mode as reported on the result channel
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_HEAT = 2'd1,
		MODE_COOL = 2'd2
	} mode_t;

	// configuration register indexes
	localparam int unsigned CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] CFG_MIN_COOL_ON  = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_MIN_COOL_OFF = 1'b1;

	localparam int unsigned StampW = 32;
	localparam int unsigned PidW   = 16;
	localparam int unsigned DutyW  = 15;

	// Q8.8 thresholds: 1.0 and 100.0
	localparam logic signed [PidW-1:0] ONE_Q88  = 16'sd256;
	localparam logic signed [PidW-1:0] FULL_Q88 = 16'sd25600;

	// controller state carried from item to item
	typedef struct packed {
		mode_t              mode;
		logic               cooler_active;
		logic [StampW-1:0]  start_stamp;
		logic [StampW-1:0]  stop_stamp;
		logic [DutyW-1:0]   heat_level;
		logic [DutyW-1:0]   cool_level;
	} ctl_state_t;

	localparam ctl_state_t CTL_STATE_RESET = '{
		mode:          MODE_IDLE,
		cooler_active: 1'b0,
		start_stamp:   '0,
		stop_stamp:    '0,
		heat_level:    '0,
		cool_level:    '0
	};

endpackage

[rtl/hcs_decide.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_decide
// Mode selection and compressor on/off time guard for one controller sample.
// ----------------------------------------------------------------------------
module hcs_decide (
	input  logic [hcs_pkg::StampW-1:0]        now_ms,
	input  logic signed [hcs_pkg::PidW-1:0]   pid_output,
	input  logic [hcs_pkg::StampW-1:0]        min_cool_on_ms,
	input  logic [hcs_pkg::StampW-1:0]        min_cool_off_ms,
	input  hcs_pkg::ctl_state_t               cur,
	output hcs_pkg::ctl_state_t               nxt
);

	logic signed [hcs_pkg::PidW-1:0] p_sat;
	logic signed [hcs_pkg::PidW-1:0] p_neg;
	logic [hcs_pkg::StampW-1:0]      since_start;
	logic [hcs_pkg::StampW-1:0]      since_stop;
	logic                            on_guard;
	logic                            off_hold;

	// saturate to +-100.0
	always_comb begin
		if (pid_output > hcs_pkg::FULL_Q88) begin
			p_sat = hcs_pkg::FULL_Q88;
		end else if (pid_output < -hcs_pkg::FULL_Q88) begin
			p_sat = -hcs_pkg::FULL_Q88;
		end else begin
			p_sat = pid_output;
		end
	end

	assign p_neg       = -p_sat;
	assign since_start = now_ms - cur.start_stamp;
	assign since_stop  = now_ms - cur.stop_stamp;
	assign on_guard    = cur.cooler_active && (since_start < min_cool_on_ms);
	assign off_hold    = !cur.cooler_active && (cur.stop_stamp != '0)
		&& (since_stop < min_cool_off_ms);

	always_comb begin
		nxt = cur;
		if (p_sat > hcs_pkg::ONE_Q88) begin
			if (!on_guard) begin
				if (cur.cooler_active) begin
					nxt.cooler_active = 1'b0;
					nxt.cool_level    = '0;
					nxt.start_stamp   = '0;
					if (cur.stop_stamp == '0) begin
						nxt.stop_stamp = now_ms;
					end
				end
				nxt.heat_level = p_sat[hcs_pkg::DutyW-1:0];
				nxt.mode       = hcs_pkg::MODE_HEAT;
			end
		end else if (p_sat < -hcs_pkg::ONE_Q88) begin
			if (!off_hold) begin
				nxt.heat_level = '0;
				if (cur.start_stamp == '0) begin
					nxt.start_stamp = now_ms;
					nxt.stop_stamp  = '0;
				end
				nxt.cooler_active = 1'b1;
				nxt.cool_level    = p_neg[hcs_pkg::DutyW-1:0];
				nxt.mode          = hcs_pkg::MODE_COOL;
			end
		end else begin
			nxt.heat_level = '0;
			if (!on_guard) begin
				if (cur.cooler_active) begin
					nxt.cooler_active = 1'b0;
					nxt.cool_level    = '0;
					nxt.start_stamp   = '0;
					if (cur.stop_stamp == '0) begin
						nxt.stop_stamp = now_ms;
					end
				end
				nxt.mode = hcs_pkg::MODE_IDLE;
			end
		end
	end

endmodule

[rtl/heat_cool_selector_with_compressor_guard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_cool_selector_with_compressor_guard
// Picks heating, cooling or idle from a Q8.8 controller output and enforces
// minimum compressor on-time and off-time.
// ----------------------------------------------------------------------------
// Each input transfer carries a millisecond timestamp and a signed Q8.8
// controller output; each one produces exactly one result transfer with the
// mode, heater duty, cooler duty and compressor state after that sample.
// The block takes one input transfer per clock while the result register can
// drain. Acceptance loads the input register, and the result register loads
// from it once the result slot is free. A single decision path between those
// two registers also updates the stored controller state. A full result
// register backs up into the input register, so one more sample can be taken
// while a result waits; after that the input stalls until the result transfer
// completes.
// Configuration writes (index 0: minimum on-time, index 1: minimum off-time,
// both in ms) are always accepted and take effect on the next sample.
// ----------------------------------------------------------------------------
module heat_cool_selector_with_compressor_guard (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hcs_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [hcs_pkg::StampW-1:0]          cfg_data,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [hcs_pkg::StampW-1:0]          now_ms,
	input  logic signed [hcs_pkg::PidW-1:0]     pid_output,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          mode,
	output logic [hcs_pkg::DutyW-1:0]           heater_duty,
	output logic [hcs_pkg::DutyW-1:0]           cooler_duty,
	output logic                                cooler_running
);

	// configuration registers
	logic [hcs_pkg::StampW-1:0] min_on_q;
	logic [hcs_pkg::StampW-1:0] min_off_q;

	// input stage
	logic                            valid_s1;
	logic [hcs_pkg::StampW-1:0]      now_s1;
	logic signed [hcs_pkg::PidW-1:0] pid_s1;

	// stored controller state and its next value
	hcs_pkg::ctl_state_t state_q;
	hcs_pkg::ctl_state_t state_nxt;

	// result register
	logic                       out_valid_q;
	hcs_pkg::mode_t             mode_q;
	logic [hcs_pkg::DutyW-1:0]  heat_q;
	logic [hcs_pkg::DutyW-1:0]  cool_q;
	logic                       running_q;

	logic out_free;
	logic advance;

	// result slot frees up when empty or being drained this cycle
	assign out_free  = !out_valid_q || out_ready;
	// the sample in the input stage is decided and committed
	assign advance   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_on_q  <= '0;
			min_off_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				hcs_pkg::CFG_MIN_COOL_ON:  min_on_q  <= cfg_data;
				hcs_pkg::CFG_MIN_COOL_OFF: min_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			now_s1 <= now_ms;
			pid_s1 <= pid_output;
		end
	end

	hcs_decide u_decide (
		.now_ms          (now_s1),
		.pid_output      (pid_s1),
		.min_cool_on_ms  (min_on_q),
		.min_cool_off_ms (min_off_q),
		.cur             (state_q),
		.nxt             (state_nxt)
	);

	// controller state commits once per decided sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcs_pkg::CTL_STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_q    <= state_nxt.mode;
			heat_q    <= state_nxt.heat_level;
			cool_q    <= state_nxt.cool_level;
			running_q <= state_nxt.cooler_active;
		end
	end

	assign out_valid      = out_valid_q;
	assign mode           = mode_q;
	assign heater_duty    = heat_q;
	assign cooler_duty    = cool_q;
	assign cooler_running = running_q;

endmodule
